// ===== src/blifo_pkg.sv =====
// Shared constants for the bounded LIFO stack: command and status codes,
// stream field positions and default sizes. No dependencies.
package blifo_pkg;

	localparam int DEF_STACK_DEPTH   = 64;
	localparam int DEF_ELEMENT_WIDTH = 32;
	localparam int QUEUE_DEPTH       = 2;

	localparam int CMD_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int CAP_W    = 7;
	localparam int OCC_W    = 7;

	localparam int IN_DATA_W   = CMD_W + VALUE_W;
	localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
	localparam int OUT_DATA_W  = VALUE_W + STATUS_W + OCC_W;
	localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	typedef logic [CMD_W-1:0] op_t;

	localparam op_t OP_PUSH        = 3'd0;
	localparam op_t OP_POP         = 3'd1;
	localparam op_t OP_PEEK_TOP    = 3'd2;
	localparam op_t OP_PEEK_BOTTOM = 3'd3;
	localparam op_t OP_POP_ALL     = 3'd4;
	localparam op_t OP_CLEAR       = 3'd5;
	localparam op_t OP_NOP         = 3'd6;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

endpackage

// ===== src/blifo_front.sv =====
// Front end of the bounded LIFO stack: accepts input transfers and decodes
// the command into an internal operation. Depends on blifo_pkg.
module blifo_front #(
	parameter int ELEMENT_WIDTH = blifo_pkg::DEF_ELEMENT_WIDTH
) (
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// Fields from bit 0 up: command, push_value.
	input  logic [blifo_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                              q_full,
	output logic                              q_push,
	output blifo_pkg::op_t                    q_op,
	output logic [ELEMENT_WIDTH-1:0]          q_elem
);
	import blifo_pkg::*;

	logic [CMD_W-1:0]                 cmd;
	logic [VALUE_W-1:0]               push_value;
	logic [ELEMENT_WIDTH+VALUE_W-1:0] elem_wide;

	assign cmd        = s_tdata[CMD_W-1:0];
	assign push_value = s_tdata[CMD_W +: VALUE_W];
	assign elem_wide  = {{ELEMENT_WIDTH{1'b0}}, push_value};

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;
	assign q_elem   = elem_wide[ELEMENT_WIDTH-1:0];

	always_comb begin
		unique case (cmd)
			OP_PUSH:        q_op = OP_PUSH;
			OP_POP:         q_op = OP_POP;
			OP_PEEK_TOP:    q_op = OP_PEEK_TOP;
			OP_PEEK_BOTTOM: q_op = OP_PEEK_BOTTOM;
			OP_POP_ALL:     q_op = OP_POP_ALL;
			OP_CLEAR:       q_op = OP_CLEAR;
			default:        q_op = OP_NOP;
		endcase
	end

endmodule

// ===== src/blifo_queue.sv =====
// Short register queue between the front and back ends of the LIFO stack.
// Depends on blifo_pkg for its depth.
module blifo_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] pop_data
);
	import blifo_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	assign full     = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign valid    = (fill_q != '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue written while full");
	assert property (@(posedge clk) disable iff (!arst_n) !valid |-> !pop)
		else $error("queue read while empty");
	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue fill count out of range");

endmodule

// ===== src/blifo_back.sv =====
// Back end of the LIFO stack: entry memory, occupancy, capacity register and
// the output register that drives result transfers. Depends on blifo_pkg.
module blifo_back #(
	parameter int STACK_DEPTH   = blifo_pkg::DEF_STACK_DEPTH,
	parameter int ELEMENT_WIDTH = blifo_pkg::DEF_ELEMENT_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [blifo_pkg::CAP_W-1:0]       cfg_data,
	input  logic                              q_valid,
	output logic                              q_ready,
	input  blifo_pkg::op_t                    q_op,
	input  logic [ELEMENT_WIDTH-1:0]          q_elem,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// Fields from bit 0 up: value, status, occupancy.
	output logic [blifo_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                              m_tlast
);
	import blifo_pkg::*;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int AW    = $clog2(STACK_DEPTH);

	logic [ELEMENT_WIDTH-1:0] mem_q [STACK_DEPTH];
	logic [ELEMENT_WIDTH-1:0] rd_q;
	logic [CNT_W-1:0]         count_q;
	logic [CAP_W-1:0]         cap_q;
	logic                     popall_q;
	logic [AW-1:0]            idx_q;

	logic                     out_valid_q;
	status_t                  status_q;
	logic                     last_q;
	logic [OCC_W-1:0]         occ_q;
	logic                     use_mem_q;

	logic                     load;
	logic [CAP_W-1:0]         eff_cap;
	logic                     is_full;
	logic                     is_empty;
	logic [AW-1:0]            top_addr;
	logic [AW-1:0]            rd_addr;
	logic                     wr_en;
	status_t                  n_status;
	logic                     n_last;
	logic [OCC_W-1:0]         n_occ;
	logic                     n_use_mem;
	logic [CNT_W-1:0]         n_count;
	logic                     n_popall;
	logic [AW-1:0]            n_idx;
	logic [ELEMENT_WIDTH+VALUE_W-1:0] out_wide;

	assign cfg_ready = 1'b1;
	assign load      = (popall_q || q_valid) && (!out_valid_q || m_tready);
	assign q_ready   = load && !popall_q;

	assign eff_cap  = (cap_q > CAP_W'(STACK_DEPTH)) ? CAP_W'(STACK_DEPTH) : cap_q;
	assign is_full  = (CAP_W'(count_q) >= eff_cap);
	assign is_empty = (count_q == '0);
	assign top_addr = AW'(count_q - CNT_W'(1));

	always_comb begin
		rd_addr   = top_addr;
		wr_en     = 1'b0;
		n_status  = ST_OK;
		n_last    = 1'b1;
		n_occ     = OCC_W'(count_q);
		n_use_mem = 1'b0;
		n_count   = count_q;
		n_popall  = popall_q;
		n_idx     = idx_q;
		if (popall_q) begin
			rd_addr   = idx_q;
			n_use_mem = 1'b1;
			n_occ     = OCC_W'(idx_q);
			n_count   = CNT_W'(idx_q);
			n_last    = (idx_q == '0);
			n_popall  = (idx_q != '0);
			n_idx     = idx_q - 1'b1;
		end else begin
			unique case (q_op)
				OP_PUSH: begin
					if (is_full) begin
						n_status = ST_FULL;
					end else begin
						wr_en   = 1'b1;
						n_count = count_q + 1'b1;
						n_occ   = OCC_W'(count_q + 1'b1);
					end
				end
				OP_POP: begin
					if (is_empty) begin
						n_status = ST_EMPTY;
					end else begin
						n_use_mem = 1'b1;
						n_count   = count_q - 1'b1;
						n_occ     = OCC_W'(count_q - 1'b1);
					end
				end
				OP_PEEK_TOP: begin
					if (is_empty) begin
						n_status = ST_EMPTY;
					end else begin
						n_use_mem = 1'b1;
					end
				end
				OP_PEEK_BOTTOM: begin
					rd_addr = '0;
					if (is_empty) begin
						n_status = ST_EMPTY;
					end else begin
						n_use_mem = 1'b1;
					end
				end
				OP_POP_ALL: begin
					if (is_empty) begin
						n_status = ST_EMPTY;
					end else begin
						n_use_mem = 1'b1;
						n_count   = count_q - 1'b1;
						n_occ     = OCC_W'(count_q - 1'b1);
						n_last    = (count_q == CNT_W'(1));
						n_popall  = (count_q != CNT_W'(1));
						n_idx     = AW'(count_q - CNT_W'(2));
					end
				end
				OP_CLEAR: begin
					n_count = '0;
					n_occ   = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load && wr_en) begin
			mem_q[count_q[AW-1:0]] <= q_elem;
		end
		if (load) begin
			rd_q      <= mem_q[rd_addr];
			status_q  <= n_status;
			last_q    <= n_last;
			occ_q     <= n_occ;
			use_mem_q <= n_use_mem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= CAP_RESET;
			popall_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (load) begin
				count_q     <= n_count;
				popall_q    <= n_popall;
				idx_q       <= n_idx;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_wide = use_mem_q ? {{VALUE_W{1'b0}}, rd_q} : '0;
	assign m_tvalid = out_valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{(OUT_TDATA_W - OUT_DATA_W){1'b0}}, occ_q, status_q,
		out_wide[VALUE_W-1:0]};

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(STACK_DEPTH))
		else $error("occupancy above stack depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		popall_q |-> (count_q == CNT_W'(idx_q) + CNT_W'(1)))
		else $error("pop all index out of step with occupancy");
	assert property (@(posedge clk) disable iff (!arst_n) popall_q |-> !q_ready)
		else $error("queue drained during pop all");
	assert property (@(posedge clk) disable iff (!arst_n)
		(load && !popall_q && q_op == OP_PUSH && !is_full)
		|=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("accepted push did not raise occupancy");

endmodule

// ===== src/bounded_lifo_stack_top.sv =====
// Top level of the bounded LIFO stack: front end, command queue and back end.
// Depends on blifo_pkg, blifo_front, blifo_queue and blifo_back.
//
//  Channel   Handshake            Payload
//  s_*       s_tvalid/s_tready    s_tdata: command[2:0], push_value[34:3]
//  m_*       m_tvalid/m_tready    m_tdata: value[31:0], status[33:32],
//                                 occupancy[40:34]; m_tlast: last
//  cfg_*     cfg_valid/cfg_ready  cfg_data: capacity_limit
//
// Pop all gives one result per cycle while the output is not stalled, one per
// held entry. A command passes through the command queue and then the output
// register before its result is offered.
// Reset clears occupancy and sets the capacity to 64; entries are not cleared.
// A stalled output holds the back end; the two-entry queue keeps input open
// for two more transfers.
module bounded_lifo_stack_top #(
	parameter int STACK_DEPTH   = blifo_pkg::DEF_STACK_DEPTH,
	parameter int ELEMENT_WIDTH = blifo_pkg::DEF_ELEMENT_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// Fields from bit 0 up: command, push_value.
	input  logic [blifo_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// Fields from bit 0 up: value, status, occupancy.
	output logic [blifo_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                              m_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [blifo_pkg::CAP_W-1:0]       cfg_data
);
	import blifo_pkg::*;

	localparam int QW = CMD_W + ELEMENT_WIDTH;

	logic                     q_full;
	logic                     q_push;
	op_t                      f_op;
	logic [ELEMENT_WIDTH-1:0] f_elem;
	logic                     q_valid;
	logic                     q_ready;
	logic [QW-1:0]            q_head;
	op_t                      b_op;
	logic [ELEMENT_WIDTH-1:0] b_elem;

	assign b_op   = q_head[QW-1 -: CMD_W];
	assign b_elem = q_head[ELEMENT_WIDTH-1:0];

	blifo_front #(
		.ELEMENT_WIDTH(ELEMENT_WIDTH)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_op     (f_op),
		.q_elem   (f_elem)
	);

	blifo_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({f_op, f_elem}),
		.full      (q_full),
		.pop       (q_ready),
		.valid     (q_valid),
		.pop_data  (q_head)
	);

	blifo_back #(
		.STACK_DEPTH   (STACK_DEPTH),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_op      (b_op),
		.q_elem    (b_elem),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for bounded_lifo_stack_top: directed and random command streams,
// checked transfer by transfer against a built-in model of the stack.
// Depends on blifo_pkg and the bounded_lifo_stack_top RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import blifo_pkg::*;

	localparam int STACK_SLOTS  = DEF_STACK_DEPTH;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 200;
	localparam op_t OP_RSVD     = 3'd7;

	typedef struct {
		op_t              op;
		logic [VALUE_W-1:0] operand;
	} stack_cmd_t;

	typedef struct {
		logic [VALUE_W-1:0] value;
		status_t            status;
		logic               last;
		logic [OCC_W-1:0]   occ;
	} stack_result_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CAP_W-1:0]       cfg_data  = CAP_RESET;

	logic [VALUE_W-1:0] stack_mem [STACK_SLOTS];
	int unsigned        stack_cnt = 0;
	logic [CAP_W-1:0]   cap_limit = CAP_RESET;
	stack_result_t      expected_results [$];
	stack_cmd_t         pending_cmds [$];
	stack_cmd_t         cur_cmd;

	logic cmd_taken  = 1'b0;
	logic idle_en    = 1'b1;
	logic hold_start = 1'b0;
	logic rx_hold    = 1'b0;
	int   hold_left  = 0;
	int   tx_gap     = 0;
	int   rx_gap     = 0;

	int n_queued     = 0;
	int n_accepted   = 0;
	int results_seen = 0;
	int mismatches   = 0;
	int full_cnt     = 0;
	int empty_cnt    = 0;
	int pop_all_cnt  = 0;
	int max_depth    = 0;
	int cycles       = 0;

	bounded_lifo_stack_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void add_result(logic [VALUE_W-1:0] value, status_t status, logic last,
			int unsigned occ);
		stack_result_t r;
		r.value  = value;
		r.status = status;
		r.last   = last;
		r.occ    = OCC_W'(occ);
		expected_results.push_back(r);
	endfunction

	function automatic void apply_stack_cmd(stack_cmd_t c);
		int unsigned eff_cap;
		eff_cap = (cap_limit > STACK_SLOTS) ? STACK_SLOTS : cap_limit;
		case (c.op)
			OP_PUSH: begin
				if (stack_cnt >= eff_cap) begin
					full_cnt++;
					add_result('0, ST_FULL, 1'b1, stack_cnt);
				end else begin
					stack_mem[stack_cnt] = c.operand;
					stack_cnt++;
					add_result('0, ST_OK, 1'b1, stack_cnt);
				end
			end
			OP_POP, OP_PEEK_TOP, OP_PEEK_BOTTOM, OP_POP_ALL: begin
				if (stack_cnt == 0) begin
					empty_cnt++;
					add_result('0, ST_EMPTY, 1'b1, 0);
				end else if (c.op == OP_POP) begin
					stack_cnt--;
					add_result(stack_mem[stack_cnt], ST_OK, 1'b1, stack_cnt);
				end else if (c.op == OP_PEEK_TOP) begin
					add_result(stack_mem[stack_cnt-1], ST_OK, 1'b1, stack_cnt);
				end else if (c.op == OP_PEEK_BOTTOM) begin
					add_result(stack_mem[0], ST_OK, 1'b1, stack_cnt);
				end else begin
					pop_all_cnt++;
					for (int i = stack_cnt; i > 0; i--)
						add_result(stack_mem[i-1], ST_OK, i == 1, i - 1);
					stack_cnt = 0;
				end
			end
			OP_CLEAR: begin
				stack_cnt = 0;
				add_result('0, ST_OK, 1'b1, 0);
			end
			default: begin
				add_result('0, ST_OK, 1'b1, stack_cnt);
			end
		endcase
		if (stack_cnt > max_depth)
			max_depth = stack_cnt;
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("tb: mismatch at cycle %0d: %s", cycles, msg);
	endtask

	task automatic queue_cmd(op_t op, logic [VALUE_W-1:0] operand);
		stack_cmd_t c;
		c.op      = op;
		c.operand = operand;
		pending_cmds.push_back(c);
		n_queued++;
	endtask

	task automatic queue_pushes(int n);
		for (int i = 0; i < n; i++)
			queue_cmd(OP_PUSH, $urandom());
	endtask

	task automatic queue_random(int n, int push_pct);
		int r;
		op_t op;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < push_pct) begin
				op = OP_PUSH;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 40)
					op = OP_POP;
				else if (r < 62)
					op = OP_PEEK_TOP;
				else if (r < 80)
					op = OP_PEEK_BOTTOM;
				else if (r < 87)
					op = OP_POP_ALL;
				else if (r < 92)
					op = OP_CLEAR;
				else if (r < 96)
					op = OP_NOP;
				else
					op = OP_RSVD;
			end
			queue_cmd(op, $urandom());
		end
	endtask

	task automatic wait_drained();
		while (n_accepted != n_queued || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] cap);
		wait_drained();
		@(negedge clk);
		cfg_data  <= cap;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cap_limit = cap;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin : drive_cmds
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || cmd_taken) begin
			cmd_taken = 1'b0;
			if (tx_gap > 0) begin
				tx_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_cmds.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				tx_gap = $urandom_range(0, 6);
				s_tvalid <= 1'b0;
			end else begin
				cur_cmd = pending_cmds.pop_front();
				s_tdata  <= IN_TDATA_W'({cur_cmd.operand, cur_cmd.op});
				s_tvalid <= 1'b1;
			end
		end
	end

	always @(negedge clk) begin : count_hold
		if (hold_start) begin
			hold_start = 1'b0;
			hold_left  = HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left--;
		end
		rx_hold <= (hold_left > 0);
	end

	always @(negedge clk) begin : drive_ready
		if (rx_hold) begin
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_tready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			rx_gap = $urandom_range(0, 6);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		stack_result_t      want;
		logic [VALUE_W-1:0] got_value;
		status_t            got_status;
		logic [OCC_W-1:0]   got_occ;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_value  = m_tdata[VALUE_W-1:0];
				got_status = m_tdata[VALUE_W +: STATUS_W];
				got_occ    = m_tdata[VALUE_W+STATUS_W +: OCC_W];
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result value=%h status=%0d last=%0d occ=%0d",
						got_value, got_status, m_tlast, got_occ));
				end else begin
					want = expected_results.pop_front();
					if (got_value !== want.value || got_status !== want.status ||
							m_tlast !== want.last || got_occ !== want.occ)
						report_mismatch($sformatf(
							"expected value=%h status=%0d last=%0d occ=%0d, got value=%h status=%0d last=%0d occ=%0d",
							want.value, want.status, want.last, want.occ,
							got_value, got_status, m_tlast, got_occ));
				end
			end
			if (s_tvalid && s_tready) begin
				apply_stack_cmd(cur_cmd);
				cmd_taken = 1'b1;
				n_accepted++;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles", cycles);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_capacity(CAP_W'(3));
		queue_cmd(OP_POP, 32'h1234_5678);
		queue_cmd(OP_PEEK_TOP, 32'hFFFF_FFFF);
		queue_cmd(OP_PEEK_BOTTOM, '0);
		queue_cmd(OP_POP_ALL, 32'hDEAD_BEEF);
		queue_cmd(OP_CLEAR, '0);
		queue_cmd(OP_PUSH, 32'h0000_0000);
		queue_cmd(OP_PUSH, 32'hFFFF_FFFF);
		queue_cmd(OP_PUSH, 32'hA5A5_5A5A);
		queue_cmd(OP_PUSH, 32'h0000_0001);
		queue_cmd(OP_PEEK_TOP, '0);
		queue_cmd(OP_PEEK_BOTTOM, '0);
		queue_cmd(OP_POP, '0);
		queue_cmd(OP_NOP, 32'hFFFF_FFFF);
		queue_cmd(OP_RSVD, 32'h5555_AAAA);
		queue_cmd(OP_POP_ALL, '0);
		queue_cmd(OP_PUSH, 32'h8000_0000);
		queue_cmd(OP_CLEAR, 32'hFFFF_FFFF);

		write_capacity(CAP_W'(0));
		queue_cmd(OP_PUSH, 32'h7FFF_FFFF);

		// Lowering the capacity below the current fill refuses pushes but keeps entries.
		write_capacity(CAP_W'(4));
		queue_pushes(4);
		write_capacity(CAP_W'(2));
		queue_cmd(OP_PUSH, $urandom());
		queue_cmd(OP_PEEK_BOTTOM, '0);
		queue_cmd(OP_POP_ALL, '0);

		write_capacity(CAP_W'(127));
		queue_pushes(70);
		queue_random(30, 50);
		queue_cmd(OP_POP_ALL, '0);

		write_capacity(CAP_W'(64));
		@(posedge clk);
		hold_start = 1'b1;
		queue_random(120, 60);

		write_capacity(CAP_W'(1));
		queue_random(40, 50);

		write_capacity(CAP_W'($urandom_range(2, 63)));
		queue_random(80, 55);

		write_capacity(CAP_W'(64));
		@(posedge clk);
		idle_en = 1'b0;
		queue_pushes(20);
		queue_random(40, 55);
		queue_cmd(OP_POP_ALL, '0);

		wait_drained();
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

		$display("tb: %0d commands transferred, %0d results checked, %0d pop-all runs",
			n_accepted, results_seen, pop_all_cnt);
		$display("tb: %0d full refusals, %0d empty reads, deepest stack %0d, %0d mismatches",
			full_cnt, empty_cnt, max_depth, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
